FILE: hdl/cbe_pkg.sv
package cbe_pkg;

	localparam int PROG_W = 17;
	localparam int CX_W   = 17;
	localparam int CY_W   = 19;
	localparam int CFG_W  = 19;
	localparam int CIDX_W = 2;

	localparam logic [CIDX_W-1:0] CFG_X1 = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_Y1 = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_X2 = 2'd2;
	localparam logic [CIDX_W-1:0] CFG_Y2 = 2'd3;

	localparam logic [CX_W-1:0]        X1_RST = 17'd16384;
	localparam logic signed [CY_W-1:0] Y1_RST = 19'sd6554;
	localparam logic [CX_W-1:0]        X2_RST = 17'd16384;
	localparam logic signed [CY_W-1:0] Y2_RST = 19'sd65536;

	// multiply steps of one curve evaluation, in issue order
	typedef enum logic [3:0] {
		ST_UU,  // uu = u*u
		ST_SS,  // ss = s*s
		ST_A,   // tmp = uu*s
		ST_FA,  // accf += 3*tmp*p1
		ST_B,   // tmp = u*ss
		ST_FB,  // accf += 3*tmp*p2
		ST_FC,  // accf += ss*s (last step of the y pass)
		ST_D1,  // accd += uu*p1
		ST_US,  // tmp = u*s
		ST_D2,  // accd += 2*tmp*(p2-p1)
		ST_D3   // accd += ss*(1-p2)
	} step_t;

	typedef struct packed {
		logic  start;
		logic  mul_a;
		logic  mul_b;
		step_t step;
		logic  ypass;
		logic  div_init;
		logic  div_step;
		logic  upd;
		logic  load_out;
	} cbe_cmd_t;

	typedef struct packed {
		logic df_zero;
	} cbe_stat_t;

endpackage

FILE: hdl/cbe_datapath.sv
module cbe_datapath import cbe_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic [PROG_W-1:0] progress,
	input  cbe_cmd_t          cmd,
	output cbe_stat_t         status,
	output logic [PROG_W-1:0] eased
);

	localparam int MW  = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 3;
	localparam int PW  = 2 * MW;
	localparam int AW  = MW + 4;
	localparam int DFW = AW + 2;
	localparam int QB  = FRAC_BITS + 2;
	localparam int XW  = DFW + QB + FRAC_BITS;
	localparam int SW  = FRAC_BITS + 4;

	localparam logic signed [MW-1:0] ONE_Q  = MW'(64'sd1 <<< FRAC_BITS);
	localparam logic signed [PW-1:0] HALF_Q = PW'(64'sd1 <<< (FRAC_BITS - 1));
	localparam logic signed [SW-1:0] ONE_S  = SW'(64'sd1 <<< FRAC_BITS);
	localparam logic signed [AW-1:0] ONE_A  = AW'(64'sd1 <<< FRAC_BITS);

	logic [CX_W-1:0]        cx1_q, cx2_q;
	logic signed [CY_W-1:0] cy1_q, cy2_q;

	logic signed [MW-1:0] t_q, s_q, uu_q, ss_q, tmp_q;
	logic signed [AW-1:0] accf_q, accd_q;
	logic signed [PW-1:0] prod_s1;
	logic [XW-1:0]        rem_q, dsh_q;
	logic [QB-1:0]        quo_q;
	logic                 neg_q, ovf_q;
	logic [PROG_W-1:0]    eased_q;

	logic signed [MW-1:0] u, p1, p2, op_a, op_b, t_in, s_in;
	logic signed [PW-1:0] rnd;
	logic signed [AW-1:0] mres;
	logic signed [DFW-1:0] dfv;
	logic [AW-1:0]        fmag;
	logic [DFW-1:0]       dmag;
	logic [QB-1:0]        qmag;
	logic signed [SW-1:0] qsig, snew;
	logic [AW-1:0]        yc;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx1_q <= X1_RST;
			cy1_q <= Y1_RST;
			cx2_q <= X2_RST;
			cy2_q <= Y2_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_X1:  cx1_q <= cfg_wdata[CX_W-1:0];
				CFG_Y1:  cy1_q <= $signed(cfg_wdata[CY_W-1:0]);
				CFG_X2:  cx2_q <= cfg_wdata[CX_W-1:0];
				CFG_Y2:  cy2_q <= $signed(cfg_wdata[CY_W-1:0]);
				default: ;
			endcase
		end
	end

	assign u    = ONE_Q - s_q;
	assign p1   = cmd.ypass ? MW'(cy1_q) : MW'($signed({1'b0, cx1_q}));
	assign p2   = cmd.ypass ? MW'(cy2_q) : MW'($signed({1'b0, cx2_q}));
	assign t_in = MW'($signed({1'b0, progress}));
	assign s_in = (t_in > ONE_Q) ? ONE_Q : t_in;

	always_comb begin
		op_a = s_q;
		op_b = s_q;
		case (cmd.step)
			ST_UU: begin op_a = u;     op_b = u;          end
			ST_SS: begin op_a = s_q;   op_b = s_q;        end
			ST_A:  begin op_a = uu_q;  op_b = s_q;        end
			ST_FA: begin op_a = tmp_q; op_b = p1;         end
			ST_B:  begin op_a = u;     op_b = ss_q;       end
			ST_FB: begin op_a = tmp_q; op_b = p2;         end
			ST_FC: begin op_a = ss_q;  op_b = s_q;        end
			ST_D1: begin op_a = uu_q;  op_b = p1;         end
			ST_US: begin op_a = u;     op_b = s_q;        end
			ST_D2: begin op_a = tmp_q; op_b = p2 - p1;    end
			ST_D3: begin op_a = ss_q;  op_b = ONE_Q - p2; end
			default: ;
		endcase
	end

	// round to nearest, ties up: floor((p + half) / 2^F)
	assign rnd  = (prod_s1 + HALF_Q) >>> FRAC_BITS;
	assign mres = AW'(rnd);

	assign dfv  = DFW'(accd_q) + DFW'(accd_q) + DFW'(accd_q);
	assign fmag = accf_q[AW-1] ? AW'(-accf_q) : AW'(accf_q);
	assign dmag = dfv[DFW-1] ? DFW'(-dfv) : DFW'(dfv);
	assign status.df_zero = (accd_q == '0);

	assign qmag = ovf_q ? '1 : quo_q;
	assign qsig = neg_q ? -$signed(SW'(qmag)) : $signed(SW'(qmag));
	assign snew = SW'(s_q) - qsig;

	assign yc = (accf_q < 0) ? '0 : ((accf_q > ONE_A) ? ONE_A : accf_q);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			t_q <= t_in;
			s_q <= s_in;
		end
		if (cmd.mul_a) begin
			prod_s1 <= PW'(op_a) * PW'(op_b);
			if (cmd.step == ST_UU) begin
				accf_q <= cmd.ypass ? '0 : -AW'(t_q);
				accd_q <= '0;
			end
		end
		if (cmd.mul_b) begin
			case (cmd.step)
				ST_UU: uu_q <= MW'(mres);
				ST_SS: ss_q <= MW'(mres);
				ST_A, ST_B, ST_US: tmp_q <= MW'(mres);
				ST_FA, ST_FB: accf_q <= accf_q + mres + mres + mres;
				ST_FC: accf_q <= accf_q + mres;
				ST_D1, ST_D3: accd_q <= accd_q + mres;
				ST_D2: accd_q <= accd_q + mres + mres;
				default: ;
			endcase
		end
		if (cmd.div_init) begin
			rem_q <= XW'(fmag) << FRAC_BITS;
			dsh_q <= XW'(dmag) << (QB - 1);
			ovf_q <= (XW'(fmag) << FRAC_BITS) >= (XW'(dmag) << QB);
			neg_q <= accf_q[AW-1] ^ dfv[DFW-1];
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[QB-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QB-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
		if (cmd.upd) begin
			if (snew < 0)
				s_q <= '0;
			else if (snew > ONE_S)
				s_q <= ONE_Q;
			else
				s_q <= MW'(snew);
		end
		if (cmd.load_out)
			eased_q <= PROG_W'(yc);
	end

	assign eased = eased_q;

endmodule

FILE: hdl/cbe_ctrl.sv
module cbe_ctrl import cbe_pkg::*; #(
	parameter int NEWTON_STEPS = 8,
	parameter int FRAC_BITS    = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  cbe_stat_t status,
	output cbe_cmd_t  cmd
);

	localparam int QB = FRAC_BITS + 2;
	localparam int IW = $clog2(NEWTON_STEPS + 1);
	localparam int CW = $clog2(QB);

	typedef enum logic [2:0] {
		S_IDLE, S_MUL_A, S_MUL_B, S_CHK, S_DIV, S_UPD, S_FIN
	} state_t;

	state_t        state_q;
	step_t         step_q;
	logic          ypass_q;
	logic [IW-1:0] iter_q;
	logic [CW-1:0] cnt_q;
	logic          ovalid_q;
	logic          last_step;
	logic          out_free;

	assign last_step = ypass_q ? (step_q == ST_FC) : (step_q == ST_D3);
	assign out_free  = !ovalid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			step_q   <= ST_UU;
			ypass_q  <= 1'b0;
			iter_q   <= '0;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if ((state_q == S_FIN) && out_free)
				ovalid_q <= 1'b1;
			else if (ovalid_q && out_ready)
				ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						step_q  <= ST_UU;
						ypass_q <= 1'b0;
						iter_q  <= '0;
						state_q <= S_MUL_A;
					end
				end
				S_MUL_A: state_q <= S_MUL_B;
				S_MUL_B: begin
					if (last_step)
						state_q <= ypass_q ? S_FIN : S_CHK;
					else begin
						step_q  <= step_t'(step_q + 4'd1);
						state_q <= S_MUL_A;
					end
				end
				S_CHK: begin
					if (status.df_zero) begin
						ypass_q <= 1'b1;
						step_q  <= ST_UU;
						state_q <= S_MUL_A;
					end else begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == CW'(QB - 1))
						state_q <= S_UPD;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				S_UPD: begin
					step_q <= ST_UU;
					if (iter_q == IW'(NEWTON_STEPS - 1))
						ypass_q <= 1'b1;
					else
						iter_q <= iter_q + 1'b1;
					state_q <= S_MUL_A;
				end
				S_FIN: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.step     = step_q;
		cmd.ypass    = ypass_q;
		cmd.start    = (state_q == S_IDLE) && in_valid;
		cmd.mul_a    = (state_q == S_MUL_A);
		cmd.mul_b    = (state_q == S_MUL_B);
		cmd.div_init = (state_q == S_CHK) && !status.df_zero;
		cmd.div_step = (state_q == S_DIV);
		cmd.upd      = (state_q == S_UPD);
		cmd.load_out = (state_q == S_FIN) && out_free;
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ovalid_q;

endmodule

FILE: hdl/cubic_bezier_ease_eval.sv
// channel   | dir | handshake        | payload
// s_axis    | in  | s_tvalid/tready  | s_tdata[16:0] progress (Q16 t)
// m_axis    | out | m_tvalid/tready  | m_tdata[16:0] eased (y clamped 0..1)
// cfg       | in  | cfg_we           | cfg_idx: 0 x1, 1 y1, 2 x2, 3 y2; cfg_wdata
//
// One item at a time. Each Newton step runs 11 products on the shared
// multiplier, a derivative check, the divider and an update. After
// NEWTON_STEPS steps (8 by default) a final y pass gives the result;
// a flat derivative ends the loop early.
// Async active-low reset sets only sequencer and config registers; no clearing pass.
// A result held on m_axis does not block the next item; only the finish of
// that next item waits for the output register to free up.
module cubic_bezier_ease_eval import cbe_pkg::*; #(
	parameter int NEWTON_STEPS = 8,
	parameter int FRAC_BITS    = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [23:0]       s_tdata,   // [16:0] progress, [23:17] zero
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,   // [16:0] eased, [23:17] zero
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]  cfg_wdata
);

	cbe_cmd_t          cmd;
	cbe_stat_t         status;
	logic [PROG_W-1:0] eased;

	// sequencer: multiply steps, divider count, Newton iteration count
	cbe_ctrl #(
		.NEWTON_STEPS(NEWTON_STEPS),
		.FRAC_BITS   (FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// control registers, shared multiplier, restoring divider, output register
	cbe_datapath #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.progress (s_tdata[PROG_W-1:0]),
		.cmd      (cmd),
		.status   (status),
		.eased    (eased)
	);

	assign m_tdata = {{(24 - PROG_W){1'b0}}, eased};

endmodule

FILE: verif/cbe_checker.sv
module cbe_checker import cbe_pkg::*; #(
	parameter int FRAC_BITS    = 16,
	parameter int NEWTON_STEPS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [23:0]       s_tdata,   // [16:0] progress
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [23:0]       m_tdata,   // [16:0] eased
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]  cfg_wdata,
	output int                errors,
	output int                pending,
	output int                eased_seen
);

	localparam longint ONE  = longint'(1) << FRAC_BITS;
	localparam longint HALF = longint'(1) << (FRAC_BITS - 1);

	longint x1, y1, x2, y2;
	logic [PROG_W-1:0] eased_q[$];

	// product rounded to nearest, ties up; >>> on signed is a floor
	function automatic longint qmul(longint a, longint b);
		return (a * b + HALF) >>> FRAC_BITS;
	endfunction

	function automatic longint curve(longint s, longint p1, longint p2);
		longint u, uu, ss;
		u  = ONE - s;
		uu = qmul(u, u);
		ss = qmul(s, s);
		return 3 * qmul(qmul(uu, s), p1) + 3 * qmul(qmul(u, ss), p2) + qmul(ss, s);
	endfunction

	function automatic longint curve_slope(longint s, longint p1, longint p2);
		longint u, uu, ss;
		u  = ONE - s;
		uu = qmul(u, u);
		ss = qmul(s, s);
		return 3 * (qmul(uu, p1) + 2 * qmul(qmul(u, s), p2 - p1) + qmul(ss, ONE - p2));
	endfunction

	function automatic logic [PROG_W-1:0] ease(longint t);
		longint s, f, df, y;
		s = (t > ONE) ? ONE : t;
		for (int i = 0; i < NEWTON_STEPS; i++) begin
			f  = curve(s, x1, x2) - t;
			df = curve_slope(s, x1, x2);
			if (df == 0) break;  // flat slope: keep current s
			s = s - (f * ONE) / df;
			if (s < 0) s = 0;
			if (s > ONE) s = ONE;
		end
		y = curve(s, y1, y2);
		if (y < 0) y = 0;
		if (y > ONE) y = ONE;
		return y[PROG_W-1:0];
	endfunction

	assign pending = eased_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1 = X1_RST;
			y1 = Y1_RST;
			x2 = X2_RST;
			y2 = Y2_RST;
			eased_q.delete();
			errors     <= 0;
			eased_seen <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_X1: x1 = longint'(cfg_wdata[CX_W-1:0]);
					CFG_Y1: y1 = longint'(signed'(cfg_wdata[CY_W-1:0]));
					CFG_X2: x2 = longint'(cfg_wdata[CX_W-1:0]);
					CFG_Y2: y2 = longint'(signed'(cfg_wdata[CY_W-1:0]));
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				eased_q.push_back(ease(longint'(s_tdata[PROG_W-1:0])));
			if (m_tvalid && m_tready) begin
				eased_seen <= eased_seen + 1;
				if (eased_q.size() == 0) begin
					$error("eased: expected none, got %0d", m_tdata[PROG_W-1:0]);
					errors <= errors + 1;
				end else begin
					logic [PROG_W-1:0] want;
					want = eased_q.pop_front();
					if (m_tdata[PROG_W-1:0] !== want || m_tdata[23:PROG_W] !== '0) begin
						$error("eased: expected %0d, got %0d (pad %0h)", want,
							m_tdata[PROG_W-1:0], m_tdata[23:PROG_W]);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

FILE: verif/cubic_bezier_ease_eval_test.sv
module cubic_bezier_ease_eval_test;
	import cbe_pkg::*;

	localparam longint CYCLE_LIMIT = 2000000;
	localparam int     PHASES      = 8;
	localparam int     PER_PHASE   = 90;   // random items per phase

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid, s_tready;
	logic [23:0]       s_tdata;
	logic              m_tvalid, m_tready;
	logic [23:0]       m_tdata;
	logic              cfg_we;
	logic [CIDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]  cfg_wdata;

	int     errors, pending, eased_seen;
	int     items_sent;
	longint cycles;
	bit     no_gaps;   // phase with back-to-back traffic on both sides
	bit     rx_on;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cubic_bezier_ease_eval i_dut (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata,
		.cfg_we, .cfg_idx, .cfg_wdata
	);

	cbe_checker i_chk (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata,
		.cfg_we, .cfg_idx, .cfg_wdata,
		.errors, .pending, .eased_seen
	);

	// watchdog: a run sends 781 items; it fails once cycles passes CYCLE_LIMIT
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: random stall before taking each item, none in the no-gaps phase
	initial begin
		int w;
		m_tready <= 1'b0;
		wait (rx_on);
		forever begin
			w = no_gaps ? 0 : $urandom_range(19);
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// one progress item; valid stays up when the next one follows at once
	task automatic send_progress(logic [PROG_W-1:0] t);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, t};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	// caller lowers cfg_we after the last write
	task automatic cfg_write(logic [CIDX_W-1:0] idx, longint v);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= v[CFG_W-1:0];
		@(posedge clk);
	endtask

	// lower valid and let the checker count the last accepted item before the drain
	task automatic load_curve(longint x1, longint y1, longint x2, longint y2);
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
		cfg_write(CFG_X1, x1);
		cfg_write(CFG_Y1, y1);
		cfg_write(CFG_X2, x2);
		cfg_write(CFG_Y2, y2);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [PROG_W-1:0] rand_progress();
		// mostly the legal 0..1.0 span, some beyond to reach the clamp and bit 16
		if ($urandom_range(3) == 0) return PROG_W'($urandom());
		return PROG_W'($urandom_range(65536));
	endfunction

	function automatic longint rand_cx();
		case ($urandom_range(5))
			0: return 0;
			1: return 65536;
			default: return $urandom_range(65536);
		endcase
	endfunction

	function automatic longint rand_cy();
		case ($urandom_range(5))
			0: return -131072;
			1: return 196608;
			default: return longint'($urandom_range(327680)) - 131072;
		endcase
	endfunction

	logic [PROG_W-1:0] edge_pts[] = '{17'd0, 17'd1, 17'd2, 17'd32768, 17'd65535,
		17'd65536, 17'd65537, 17'h1FFFF, 17'h10000, 17'h0FFFF, 17'h15555, 17'h0AAAA};

	initial begin
		cycles     <= 0;
		arst_n     <= 1'b0;
		s_tvalid   <= 1'b0;
		s_tdata    <= '0;
		cfg_we     <= 1'b0;
		cfg_idx    <= CFG_X1;
		cfg_wdata  <= '0;
		no_gaps    = 1'b0;
		rx_on      = 1'b0;
		items_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		rx_on = 1'b1;

		for (int ph = 0; ph < PHASES; ph++) begin
			// phase 0 runs the reset curve; then extremes, then random curves
			case (ph)
				0: ;
				1: load_curve(0, 0, 65536, 65536);              // flat slope at both ends
				2: load_curve(0, -131072, 0, 196608);
				3: load_curve(65536, 196608, 65536, -131072);
				4: load_curve(65536, -131072, 0, -131072);
				default: load_curve(rand_cx(), rand_cy(), rand_cx(), rand_cy());
			endcase
			no_gaps = (ph == 5);
			foreach (edge_pts[k])
				if (ph == 0 || k < 7) send_progress(edge_pts[k]);
			for (int n = 0; n < PER_PHASE; n++)
				send_progress(rand_progress());
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (400) @(posedge clk);

		$display("sent %0d progress items over %0d curve settings, %0d eased results checked",
			items_sent, PHASES, eased_seen);
		if (errors == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
